/* rtl/fire_effect_heat_map_assert.svh */
// Assertion macros for the checker file of the fire heat map.
`ifndef FIRE_EFFECT_HEAT_MAP_ASSERT_SVH
`define FIRE_EFFECT_HEAT_MAP_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define FEHM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fire heat map check failed");

// Next-cycle implication, sampled on clk and held off during rst.
`define FEHM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fire heat map check failed");

`endif

/* rtl/fehm_pkg.sv */
// Package with the widths, codes and colour functions of the fire heat map.
package fehm_pkg;

  localparam int STORE_DEPTH = 65536;
  localparam int HEAT_W      = 6;
  localparam int INDEX_W     = 16;
  localparam int SHIFT_W     = 2;
  localparam int CMD_W       = 2;
  localparam int COLOR_W     = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 6;

  localparam logic [HEAT_W-1:0]  IGNITE_HEAT_RESET  = 6'd36;
  localparam logic [HEAT_W-1:0]  DECAY_AMOUNT_RESET = 6'd3;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX          = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SPREAD = 2'd0,
    CMD_COLOUR = 2'd1,
    CMD_IGNITE = 2'd2
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IGNITE_HEAT  = 1'b0,
    REG_DECAY_AMOUNT = 1'b1
  } cfg_reg_t;

  function automatic logic [COLOR_W-1:0] red_of(input logic [HEAT_W-1:0] h);
    logic [9:0] p;
    p = 10'(h) * 10'd14;
    return (p > 10'd255) ? 8'hFF : p[7:0];
  endfunction

  function automatic logic [COLOR_W-1:0] green_of(input logic [HEAT_W-1:0] h);
    logic [9:0] p;
    p = 10'(h) * 10'd14;
    return p[9] ? 8'hFF : (p[8] ? p[7:0] : 8'h00);
  endfunction

  function automatic logic [COLOR_W-1:0] blue_of(input logic [HEAT_W-1:0] h);
    logic [10:0] q;
    q = 11'(h) * 11'd28;
    return q[10] ? 8'hFF : ((q[9:8] == 2'b11) ? q[7:0] : 8'h00);
  endfunction

endpackage

/* rtl/fehm_if.sv */
// Channel interfaces for command words and result words of the fire heat map.
interface fehm_req_if
  import fehm_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [INDEX_W-1:0] cell_index;
  logic [SHIFT_W-1:0] shift;

  modport source (output valid, output cmd, output cell_index, output shift, input ready);
  modport sink   (input valid, input cmd, input cell_index, input shift, output ready);
endinterface

interface fehm_rsp_if
  import fehm_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [HEAT_W-1:0]  heat;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic               wrote;

  modport source (output valid, output heat, output red, output green, output blue,
                  output wrote, input ready);
  modport sink   (input valid, input heat, input red, input green, input blue,
                  input wrote, output ready);
endinterface

/* rtl/fire_effect_heat_map.sv */
// Fire heat map: pipelined spread, colour and ignite commands on a cell store.
//
//   channel  dir  handshake         payload
//   req      in   valid / ready     cmd, cell_index, shift
//   rsp      out  valid / ready     heat, red, green, blue, wrote
//   cfg      in   cfg_we            cfg_index, cfg_data
//
// One word per cycle is taken while rsp is not stalled and no clearing pass runs.
// Four register stages: address prep, store read, update and write, colour.
// After reset a clearing pass zeroes the store, one cell a cycle, over all
// MAP_CELLS cells (at most 65536) with req.ready low.
// A stalled rsp word freezes all stages together; nothing is dropped.
module fire_effect_heat_map
  import fehm_pkg::*;
#(
  parameter int ROW_WIDTH = 256,
  parameter int ROW_COUNT = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  fehm_req_if.sink               req,
  fehm_rsp_if.source             rsp
);

  localparam int MAP_CELLS = (ROW_WIDTH * ROW_COUNT < STORE_DEPTH) ?
                             ROW_WIDTH * ROW_COUNT : STORE_DEPTH;
  localparam int ADDR_W    = $clog2(MAP_CELLS);
  localparam int CALC_W    = INDEX_W + 2;
  localparam logic [CALC_W-1:0] MAP_CELLS_C = CALC_W'(MAP_CELLS);
  localparam logic [CALC_W-1:0] ROW_WIDTH_C = CALC_W'(ROW_WIDTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(MAP_CELLS - 1);

  typedef struct packed {
    logic              vld;
    logic [CMD_W-1:0]  cmd;
    logic              in_map;
    logic [ADDR_W-1:0] addr;
    logic              odd;
    logic              tgt_ok;
    logic [ADDR_W-1:0] tgt;
  } fetch_t;

  typedef struct packed {
    logic              vld;
    logic [HEAT_W-1:0] heat;
    logic              wrote;
    logic [ADDR_W-1:0] waddr;
    logic [HEAT_W-1:0] wdata;
  } commit_t;

  logic [HEAT_W-1:0]  mem [MAP_CELLS];
  logic [HEAT_W-1:0]  rd_data;
  logic [HEAT_W-1:0]  ignite_heat;
  logic [HEAT_W-1:0]  decay_amount;
  logic               clearing;
  logic [ADDR_W-1:0]  clr_addr;
  fetch_t             s1, s2, s1_next;
  commit_t            s3, s3_next;
  logic               out_vld;
  logic [HEAT_W-1:0]  out_heat;
  logic [COLOR_W-1:0] out_red, out_green, out_blue;
  logic               out_wrote;

  logic               advance;
  logic               accept;
  logic [SHIFT_W-1:0] shift_eff;
  logic [CALC_W-1:0]  idx_ext, sum, sub, tgt_full;
  logic               fwd_hit;
  logic [HEAT_W-1:0]  heat2, dec;
  logic               do_spread, do_ignite;

  assign advance   = !out_vld || rsp.ready;
  assign req.ready = advance && !clearing;
  assign accept    = req.valid && req.ready;

  always_comb begin
    shift_eff = (req.shift > SHIFT_MAX) ? SHIFT_MAX : req.shift;
    idx_ext   = CALC_W'(req.cell_index);
    sum       = idx_ext + CALC_W'(1);
    sub       = ROW_WIDTH_C + CALC_W'(shift_eff);
    tgt_full  = sum - sub;
    s1_next.vld    = accept;
    s1_next.cmd    = req.cmd;
    s1_next.in_map = idx_ext < MAP_CELLS_C;
    s1_next.addr   = req.cell_index[ADDR_W-1:0];
    s1_next.odd    = shift_eff[0];
    s1_next.tgt_ok = (sum >= sub) && (tgt_full < MAP_CELLS_C);
    s1_next.tgt    = tgt_full[ADDR_W-1:0];
  end

  // The word in the commit stage wrote the store on the edge that sampled rd_data.
  always_comb begin
    fwd_hit   = s3.vld && s3.wrote && (s3.waddr == s2.addr);
    heat2     = s2.in_map ? (fwd_hit ? s3.wdata : rd_data) : '0;
    dec       = s2.odd ? decay_amount : '0;
    do_spread = s2.vld && s2.in_map && (s2.cmd == CMD_SPREAD) && (heat2 >= dec) && s2.tgt_ok;
    do_ignite = s2.vld && s2.in_map && (s2.cmd == CMD_IGNITE);
    s3_next.vld   = s2.vld;
    s3_next.heat  = heat2;
    s3_next.wrote = do_spread || do_ignite;
    s3_next.waddr = do_ignite ? s2.addr : s2.tgt;
    s3_next.wdata = do_ignite ? ignite_heat : heat2 - dec;
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (advance && s3_next.wrote) begin
      mem[s3_next.waddr] <= s3_next.wdata;
    end
    if (advance) begin
      rd_data <= mem[s1.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ignite_heat  <= IGNITE_HEAT_RESET;
      decay_amount <= DECAY_AMOUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IGNITE_HEAT:  ignite_heat  <= cfg_data;
        REG_DECAY_AMOUNT: decay_amount <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.vld  <= 1'b0;
      s2.vld  <= 1'b0;
      s3.vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (advance) begin
      s1        <= s1_next;
      s2        <= s1;
      s3        <= s3_next;
      out_vld   <= s3.vld;
      out_heat  <= s3.heat;
      out_red   <= red_of(s3.heat);
      out_green <= green_of(s3.heat);
      out_blue  <= blue_of(s3.heat);
      out_wrote <= s3.wrote;
    end
  end

  assign rsp.valid = out_vld;
  assign rsp.heat  = out_heat;
  assign rsp.red   = out_red;
  assign rsp.green = out_green;
  assign rsp.blue  = out_blue;
  assign rsp.wrote = out_wrote;

endmodule

/* rtl/fehm_checker.sv */
// Port-level checker for the fire heat map and its bind to the top level.
`include "fire_effect_heat_map_assert.svh"

module fehm_checker
  import fehm_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [HEAT_W-1:0]  heat,
  input logic [COLOR_W-1:0] red,
  input logic [COLOR_W-1:0] green,
  input logic [COLOR_W-1:0] blue,
  input logic               wrote
);

  logic colour_ok;

  assign colour_ok = (red == red_of(heat)) && (green == green_of(heat)) &&
                     (blue == blue_of(heat));

  `FEHM_ASSERT_NXT(a_out_held, rsp_valid && !rsp_ready, rsp_valid)
  `FEHM_ASSERT_NXT(a_out_stable, rsp_valid && !rsp_ready, $stable(heat) && $stable(wrote))
  `FEHM_ASSERT_IMP(a_colour_map, rsp_valid, colour_ok)
  `FEHM_ASSERT_IMP(a_clear_after_reset, $past(rst), !req_ready)

endmodule

bind fire_effect_heat_map fehm_checker u_fehm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .heat      (rsp.heat),
  .red       (rsp.red),
  .green     (rsp.green),
  .blue      (rsp.blue),
  .wrote     (rsp.wrote)
);
